// File: design/linear_fade_ramp_macros.svh
// assertion macros for the linear fade ramp
`ifndef LINEAR_FADE_RAMP_MACROS_SVH
`define LINEAR_FADE_RAMP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LFR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lfr_pkg.sv
// shared types and constants of the linear fade ramp
`default_nettype none
package lfr_pkg;

	localparam int TIME_WIDTH_DEF = 16;
	localparam int LEVEL_W        = 16;
	localparam int FIELD_W        = 16;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

	// request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE,
		ST_SCALE,
		ST_COMMIT
	} lfr_state_t;

	// levels above 1.0 are taken as 1.0
	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [FIELD_W-1:0] v);
		return (v > LEVEL_ONE) ? LEVEL_ONE : v;
	endfunction

endpackage
`default_nettype wire

// File: design/lfr_req_if.sv
// request channel of the linear fade ramp
`default_nettype none
interface lfr_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic        from_present;
	logic [15:0] start_level;
	logic [15:0] target_level;
	logic [15:0] ramp_ticks;
	logic [15:0] hold_ticks;

	modport source (
		output valid, req_type, from_present, start_level, target_level,
		       ramp_ticks, hold_ticks,
		input  ready
	);
	modport sink (
		input  valid, req_type, from_present, start_level, target_level,
		       ramp_ticks, hold_ticks,
		output ready
	);
endinterface
`default_nettype wire

// File: design/lfr_rsp_if.sv
// result channel of the linear fade ramp
`default_nettype none
interface lfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;
	logic        active;

	modport source (
		output valid, level, active,
		input  ready
	);
	modport sink (
		input  valid, level, active,
		output ready
	);
endinterface
`default_nettype wire

// File: design/linear_fade_ramp.sv
// linear fade ramp: one shared multiplier and a 16-step restoring divider
// tick and plain start: MUL, LOAD, DIV, then DONE registers the result word
// from-present start: MUL to DONE, SCALE, COMMIT, MUL to DONE; words are taken only in IDLE
// the level divide runs twice there; a stalled result word holds the block in its last step
// arst_n clears the fade state to zero and sets fade_enable to 1
`default_nettype none
`include "linear_fade_ramp_macros.svh"
module linear_fade_ramp #(
	parameter int TIME_WIDTH = lfr_pkg::TIME_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lfr_req_if.sink   req,
	lfr_rsp_if.source rsp,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);

	localparam int LW = lfr_pkg::LEVEL_W;
	localparam int TW = TIME_WIDTH;
	localparam int PW = TW + LW;
	localparam int CW = (TW > lfr_pkg::FIELD_W) ? TW + 1 : lfr_pkg::FIELD_W + 1;
	localparam logic [TW-1:0] TIME_MAX = '1;
	localparam logic [TW:0]   ELAPSED_MAX = '1;
	localparam logic [3:0]    DIV_LAST = 4'd15;

	lfr_pkg::lfr_state_t state_q, state_d;

	// architectural state
	logic          enable_q;
	logic [LW-1:0] begin_q, end_q;
	logic [TW-1:0] ramp_q, hold_q;
	logic [TW:0]   elapsed_q;

	// latched start fields for from-present mode
	logic          fc_q;
	logic [LW-1:0] tgt_q;
	logic [TW-1:0] ramp_in_q, hold_in_q;
	logic [LW-1:0] pres_q, gap_q;

	// shared arithmetic
	logic [PW-1:0] prod_q;
	logic [TW:0]   rem_q;
	logic [LW-1:0] lo_q, quo_q;
	logic [3:0]    cnt_q;

	logic          rsp_valid_q;
	logic [LW-1:0] rsp_level_q;
	logic          rsp_active_q;

	// control decodes
	logic req_ready_c, do_mul_c, do_scale_c, do_load_c, do_div_c, do_commit_c, out_free_c;

	// combinational datapath
	logic [TW-1:0] ramp_c, hold_c, e_c, mul_b;
	logic [LW-1:0] tgt_c, dist_c, mul_a, lvl_c, gap_c;
	logic [TW:0]   trial_c, ramp_ext_c;
	logic [TW:0]   span_c;
	logic          act_c, up_c;

	// saturate 16-bit time fields into the time width
	always_comb begin
		ramp_c = (CW'(req.ramp_ticks) > CW'(TIME_MAX)) ? TIME_MAX : TW'(req.ramp_ticks);
		hold_c = (CW'(req.hold_ticks) > CW'(TIME_MAX)) ? TIME_MAX : TW'(req.hold_ticks);
		tgt_c  = lfr_pkg::clamp_level(req.target_level);
	end

	// interpolation operands and result
	always_comb begin
		ramp_ext_c = {1'b0, ramp_q};
		e_c        = (elapsed_q < ramp_ext_c) ? elapsed_q[TW-1:0] : ramp_q;
		up_c       = (end_q >= begin_q);
		dist_c     = up_c ? (end_q - begin_q) : (begin_q - end_q);
		mul_a      = do_scale_c ? gap_q : dist_c;
		mul_b      = do_scale_c ? ramp_in_q : e_c;
		trial_c    = {rem_q[TW-1:0], lo_q[LW-1]};
		span_c     = (TW+1)'(ramp_q) + (TW+1)'(hold_q);
		if (!enable_q || ramp_q == '0) begin
			lvl_c = end_q;
			act_c = 1'b0;
		end else begin
			lvl_c = up_c ? (begin_q + quo_q) : (begin_q - quo_q);
			act_c = (elapsed_q < span_c);
		end
		gap_c = (tgt_q >= lvl_c) ? (tgt_q - lvl_c) : (lvl_c - tgt_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfr_pkg::ST_IDLE:   if (req.valid) state_d = lfr_pkg::ST_MUL;
			lfr_pkg::ST_MUL:    state_d = lfr_pkg::ST_LOAD;
			lfr_pkg::ST_LOAD:   state_d = lfr_pkg::ST_DIV;
			lfr_pkg::ST_DIV:    if (cnt_q == DIV_LAST) state_d = lfr_pkg::ST_DONE;
			lfr_pkg::ST_DONE: begin
				priority if (fc_q) state_d = lfr_pkg::ST_SCALE;
				else if (out_free_c) state_d = lfr_pkg::ST_IDLE;
				else state_d = lfr_pkg::ST_DONE;
			end
			lfr_pkg::ST_SCALE:  state_d = lfr_pkg::ST_COMMIT;
			lfr_pkg::ST_COMMIT: state_d = lfr_pkg::ST_MUL;
			default:            state_d = lfr_pkg::ST_IDLE;
		endcase
	end

	// state decodes
	always_comb begin
		req_ready_c = 1'b0;
		do_mul_c    = 1'b0;
		do_scale_c  = 1'b0;
		do_load_c   = 1'b0;
		do_div_c    = 1'b0;
		do_commit_c = 1'b0;
		out_free_c  = !rsp_valid_q || rsp.ready;
		unique case (state_q)
			lfr_pkg::ST_IDLE:   req_ready_c = 1'b1;
			lfr_pkg::ST_MUL:    do_mul_c    = 1'b1;
			lfr_pkg::ST_LOAD:   do_load_c   = 1'b1;
			lfr_pkg::ST_DIV:    do_div_c    = 1'b1;
			lfr_pkg::ST_DONE:   ;
			lfr_pkg::ST_SCALE:  do_scale_c  = 1'b1;
			lfr_pkg::ST_COMMIT: do_commit_c = 1'b1;
			default:            ;
		endcase
	end

	assign req.ready  = req_ready_c;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.level  = rsp_level_q;
	assign rsp.active = rsp_active_q;

	// control and fade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfr_pkg::ST_IDLE;
			enable_q    <= 1'b1;
			begin_q     <= '0;
			end_q       <= '0;
			ramp_q      <= '0;
			hold_q      <= '0;
			elapsed_q   <= '0;
			fc_q        <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			// accepted word updates the state unless it starts from the present level
			if (req_ready_c && req.valid) begin
				if (req.req_type == lfr_pkg::REQ_TICK) begin
					fc_q <= 1'b0;
					if (elapsed_q != ELAPSED_MAX) elapsed_q <= elapsed_q + 1'b1;
				end else if (req.from_present) begin
					fc_q <= 1'b1;
				end else begin
					fc_q      <= 1'b0;
					begin_q   <= lfr_pkg::clamp_level(req.start_level);
					end_q     <= tgt_c;
					ramp_q    <= ramp_c;
					hold_q    <= hold_c;
					elapsed_q <= '0;
				end
			end
			// from-present start takes effect after the old level is known
			if (do_commit_c) begin
				fc_q      <= 1'b0;
				begin_q   <= pres_q;
				end_q     <= tgt_q;
				ramp_q    <= prod_q[TW+14:15];
				hold_q    <= (gap_q < lfr_pkg::LEVEL_ONE) ? '0 : hold_in_q;
				elapsed_q <= '0;
			end
			// divider step counter
			if (do_load_c) begin
				cnt_q <= '0;
			end else if (do_div_c) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// result register
			if (state_q == lfr_pkg::ST_DONE && !fc_q && out_free_c) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (req_ready_c && req.valid) begin
			tgt_q     <= tgt_c;
			ramp_in_q <= ramp_c;
			hold_in_q <= hold_c;
		end
		// shared multiplier
		if (do_mul_c || do_scale_c) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		// restoring divide by the ramp length, one quotient bit a cycle
		if (do_load_c) begin
			rem_q <= {1'b0, prod_q[PW-1:LW]};
			lo_q  <= prod_q[LW-1:0];
			quo_q <= '0;
		end else if (do_div_c) begin
			lo_q <= {lo_q[LW-2:0], 1'b0};
			if (trial_c >= ramp_ext_c) begin
				rem_q <= trial_c - ramp_ext_c;
				quo_q <= {quo_q[LW-2:0], 1'b1};
			end else begin
				rem_q <= trial_c;
				quo_q <= {quo_q[LW-2:0], 1'b0};
			end
		end
		if (state_q == lfr_pkg::ST_DONE) begin
			pres_q <= lvl_c;
			gap_q  <= gap_c;
			if (!fc_q && out_free_c) begin
				rsp_level_q  <= lvl_c;
				rsp_active_q <= act_c;
			end
		end
	end

	// checks
	`LFR_ASSERT_SAME(a_level_range, rsp_valid_q, rsp_level_q <= lfr_pkg::LEVEL_ONE, "level above 1.0")
	`LFR_ASSERT_NEXT(a_busy_after_accept, req_ready_c && req.valid, state_q == lfr_pkg::ST_MUL, "accept did not start work")
	`LFR_ASSERT_SAME(a_rem_below_div, do_div_c && ramp_q != '0, rem_q < ramp_ext_c, "divider remainder out of range")
	`LFR_ASSERT_NEXT(a_commit_clears, do_commit_c, elapsed_q == '0 && !fc_q, "commit left stale state")

endmodule
`default_nettype wire

// File: tb/sv/linear_fade_ramp_tb.sv
// self-checking testbench of the linear fade ramp: directed table, then random fades
module linear_fade_ramp_tb;

	localparam int unsigned ELAPSED_MAX = (1 << (lfr_pkg::TIME_WIDTH_DEF + 1)) - 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 60;

	typedef struct packed {
		logic        kind;
		logic        from_cur;
		logic [15:0] start_lvl;
		logic [15:0] target_lvl;
		logic [15:0] ramp;
		logic [15:0] hold;
	} fade_req_t;

	typedef struct packed {
		logic [15:0] level;
		logic        active;
	} fade_out_t;

	typedef enum logic [1:0] {EN_KEEP, EN_OFF, EN_ON} en_set_t;
	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_mode_t;

	typedef struct {
		en_set_t   en_set;
		fade_req_t word;
		logic      typed;
		fade_out_t level_out;
	} fade_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	lfr_req_if req_ch ();
	lfr_rsp_if rsp_ch ();

	linear_fade_ramp i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// fade state as the block should hold it
	logic        fade_en;
	int unsigned from_lvl;
	int unsigned to_lvl;
	int unsigned ramp_len;
	int unsigned hold_len;
	int unsigned elapsed;

	fade_out_t   pending_levels[$];
	fade_row_t   plan[$];
	int unsigned fail_cnt;
	int unsigned checked_cnt;
	int unsigned active_cnt;
	int unsigned start_cnt;
	int unsigned tick_cnt;
	int unsigned cfg_cnt;
	int unsigned burst_left;
	int unsigned ticks_left;
	int unsigned cycle_cnt;

	rx_mode_t    rx_mode;
	int unsigned rx_mode_left;
	int unsigned rx_run_left;
	logic        rx_run_val;

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned clip_level(input logic [15:0] v);
		return (v > lfr_pkg::LEVEL_ONE) ? int'(lfr_pkg::LEVEL_ONE) : int'(v);
	endfunction

	// interpolated level of the present fade state
	function automatic int unsigned fade_level();
		longint unsigned e;
		longint unsigned step;
		if (!fade_en || ramp_len == 0)
			return to_lvl;
		e = (elapsed < ramp_len) ? elapsed : ramp_len;
		if (to_lvl >= from_lvl) begin
			step = (longint'(to_lvl - from_lvl) * e) / ramp_len;
			return from_lvl + int'(step);
		end
		step = (longint'(from_lvl - to_lvl) * e) / ramp_len;
		return from_lvl - int'(step);
	endfunction

	// apply one word to the fade state and return the level it leaves
	function automatic fade_out_t fade_advance(input fade_req_t w);
		fade_out_t   o;
		int unsigned s;
		int unsigned t;
		int unsigned gap;
		longint unsigned r;
		longint unsigned h;
		if (w.kind == lfr_pkg::REQ_START) begin
			s = clip_level(w.start_lvl);
			t = clip_level(w.target_lvl);
			r = w.ramp;
			h = w.hold;
			if (w.from_cur) begin
				s = fade_level();
				gap = (t >= s) ? t - s : s - t;
				r = (r * gap) / lfr_pkg::LEVEL_ONE;
				if (gap < lfr_pkg::LEVEL_ONE)
					h = 0;
			end
			from_lvl = s;
			to_lvl = t;
			ramp_len = int'(r);
			hold_len = int'(h);
			elapsed = 0;
		end else if (elapsed < ELAPSED_MAX) begin
			elapsed++;
		end
		o.level = 16'(fade_level());
		if (!fade_en || ramp_len == 0)
			o.active = 1'b0;
		else
			o.active = (longint'(elapsed) < longint'(ramp_len) + longint'(hold_len));
		return o;
	endfunction

	function automatic fade_row_t mk_row(input en_set_t es, input logic kind, input logic fc,
			input logic [15:0] s, input logic [15:0] t, input logic [15:0] r,
			input logic [15:0] h, input logic typed, input logic [15:0] lv, input logic act);
		fade_row_t row;
		row.en_set = es;
		row.word = '{kind, fc, s, t, r, h};
		row.typed = typed;
		row.level_out = '{lv, act};
		return row;
	endfunction

	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return lfr_pkg::LEVEL_ONE;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, lfr_pkg::LEVEL_ONE));
		endcase
	endfunction

	function automatic logic [15:0] pick_ticks();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			6: return 16'($urandom_range(0, 400));
			7: return 16'($urandom);
			default: return 16'($urandom_range(1, 24));
		endcase
	endfunction

	// sender pacing: bursts of words with idle gaps in between
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			gap = $urandom_range(1, 20);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// drive one word, wait for the handshake, queue the level it should produce
	task automatic send_word(input fade_req_t w, input logic typed, input fade_out_t typed_out);
		fade_out_t predicted;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= w.kind;
		req_ch.from_present <= w.from_cur;
		req_ch.start_level <= w.start_lvl;
		req_ch.target_level <= w.target_lvl;
		req_ch.ramp_ticks <= w.ramp;
		req_ch.hold_ticks <= w.hold;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = fade_advance(w);
		pending_levels.push_back(typed ? typed_out : predicted);
		if (w.kind == lfr_pkg::REQ_START)
			start_cnt++;
		else
			tick_cnt++;
		@(negedge clk);
		pace();
	endtask

	// write fade_enable once every queued level has come back
	task automatic set_enable(input logic v);
		req_ch.valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		fade_en = v;
		cfg_cnt++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random fades: mostly a start followed by ticks through ramp and hold
	task automatic run_phase(input int unsigned n_words);
		fade_req_t w;
		for (int unsigned i = 0; i < n_words; i++) begin
			w.start_lvl = 16'($urandom);
			w.target_lvl = 16'($urandom);
			w.ramp = 16'($urandom);
			w.hold = 16'($urandom);
			w.from_cur = 1'($urandom);
			if (ticks_left == 0 || $urandom_range(0, 19) == 0) begin
				w.kind = lfr_pkg::REQ_START;
				w.from_cur = ($urandom_range(0, 9) < 4);
				w.start_lvl = pick_level();
				w.target_lvl = pick_level();
				w.ramp = pick_ticks();
				w.hold = pick_ticks();
				if (w.ramp <= 24)
					ticks_left = w.ramp + ((w.hold > 16) ? 16 : w.hold) + $urandom_range(0, 3);
				else
					ticks_left = $urandom_range(1, 30);
			end else begin
				w.kind = lfr_pkg::REQ_TICK;
				ticks_left--;
			end
			send_word(w, 1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		fade_out_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected result word: level %0d active %0d",
					rsp_ch.level, rsp_ch.active);
				fail_cnt++;
			end else begin
				want = pending_levels.pop_front();
				checked_cnt++;
				if (rsp_ch.active === 1'b1)
					active_cnt++;
				if (rsp_ch.level !== want.level) begin
					$error("level mismatch: expected %0d, got %0d", want.level, rsp_ch.level);
					fail_cnt++;
				end
				if (rsp_ch.active !== want.active) begin
					$error("active mismatch: expected %0d, got %0d", want.active, rsp_ch.active);
					fail_cnt++;
				end
			end
		end
	end

	// receiver stalls: open stretches, choppy ready, and long stalls
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		if (rx_run_left == 0) begin
			case (rx_mode)
				RX_OPEN: begin
					rx_run_val = 1'b1;
					rx_run_left = 8;
				end
				RX_CHOPPY: begin
					rx_run_val = 1'($urandom);
					rx_run_left = $urandom_range(0, 3);
				end
				default: begin
					rx_run_val = ~rx_run_val;
					rx_run_left = rx_run_val ? $urandom_range(0, 4) : $urandom_range(5, 40);
				end
			endcase
		end else begin
			rx_run_left--;
		end
		rsp_ch.ready <= rx_run_val;
	end

	// timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, pending_levels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = lfr_pkg::REQ_TICK;
		req_ch.from_present = 1'b0;
		req_ch.start_level = '0;
		req_ch.target_level = '0;
		req_ch.ramp_ticks = '0;
		req_ch.hold_ticks = '0;
		rsp_ch.ready = 1'b0;
		rx_mode = RX_OPEN;
		rx_mode_left = 0;
		rx_run_left = 0;
		rx_run_val = 1'b1;
		fail_cnt = 0;
		checked_cnt = 0;
		active_cnt = 0;
		start_cnt = 0;
		tick_cnt = 0;
		cfg_cnt = 0;
		burst_left = 0;
		ticks_left = 0;
		cycle_cnt = 0;
		fade_en = 1'b1;
		from_lvl = 0;
		to_lvl = 0;
		ramp_len = 0;
		hold_len = 0;
		elapsed = 0;

		// directed words; expected result typed where it is obvious
		// tick straight after reset: no ramp, level stays at zero
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 16'd0, 1'b0));
		// target above 1.0 with zero ramp jumps to 1.0
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b0, 16'h0, 16'hFFFF, 16'd0, 16'd5,
			1'b1, 16'd32768, 1'b0));
		// falling ramp from a start above 1.0, short hold
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b0, 16'hFFFF, 16'h0, 16'd4, 16'd2,
			1'b1, 16'd32768, 1'b1));
		repeat (6)
			plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
				1'b0, 16'd0, 1'b0));
		// from-present with a full gap keeps ramp and hold
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b1, 16'h1234, 16'h8000, 16'd3, 16'd1,
			1'b0, 16'd0, 1'b0));
		repeat (2)
			plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
				1'b0, 16'd0, 1'b0));
		// from-present mid ramp: small gap scales the ramp and clears the hold
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b1, 16'h0, 16'd20000, 16'hFFFF,
			16'hFFFF, 1'b0, 16'd0, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 16'd0, 1'b0));
		// flat fade at 1.0 with the longest ramp and hold
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b0, 16'h8000, 16'h8001, 16'hFFFF,
			16'hFFFF, 1'b1, 16'd32768, 1'b1));
		// from-present with zero gap collapses the ramp to zero
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b1, 16'h0, 16'h8000, 16'd100, 16'd7,
			1'b1, 16'd32768, 1'b0));
		// fades off: straight to target, never active
		plan.push_back(mk_row(EN_OFF, lfr_pkg::REQ_START, 1'b0, 16'd100, 16'd30000, 16'd10,
			16'd10, 1'b1, 16'd30000, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 16'd30000, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b1, 16'h0, 16'd1, 16'hFFFF, 16'hFFFF,
			1'b1, 16'd1, 1'b0));
		// fades back on mid ramp
		plan.push_back(mk_row(EN_ON, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 16'd0, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b0, 16'd1, 16'h7FFF, 16'd1, 16'd0,
			1'b0, 16'd0, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 16'd0, 1'b0));
		// tick with every ignored field at all ones
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 1'b0, 16'd0, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_START, 1'b0, 16'hFFFE, 16'h0, 16'hFFFF, 16'h0,
			1'b0, 16'd0, 1'b0));
		plan.push_back(mk_row(EN_KEEP, lfr_pkg::REQ_TICK, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 16'd0, 1'b0));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].en_set != EN_KEEP)
				set_enable(plan[i].en_set == EN_ON);
			send_word(plan[i].word, plan[i].typed, plan[i].level_out);
		end

		set_enable(1'b0);
		run_phase(60);
		set_enable(1'b1);
		run_phase(200);
		set_enable(1'($urandom));
		run_phase(90);
		set_enable(1'b1);
		run_phase(100);

		req_ch.valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d start and %0d tick words, %0d fade_enable writes",
			start_cnt, tick_cnt, cfg_cnt);
		$display("%0d results compared, %0d of them active, %0d failures",
			checked_cnt, active_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/lfr_pkg.sv
design/lfr_req_if.sv
design/lfr_rsp_if.sv
design/linear_fade_ramp.sv
tb/sv/linear_fade_ramp_tb.sv
